[src/assert_macros.svh]
// Assertion macros used by the RTL file of the decoder core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every rising edge of clock while reset is low.
`define ASSERT_SYNC(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Checks that a condition never holds at a rising edge of clock while reset is low.
`define ASSERT_NEVER(lbl, cond, msg) \
   `ASSERT_SYNC(lbl, !(cond), msg)

`endif

[src/trd_pkg.sv]
// Shared constants and types of the TGA run-length pixel decoder.
package trd_pkg;

   localparam int QUEUE_DEPTH = 4;

   localparam logic [7:0] HDR_RUN_MIN = 8'd128;
   localparam logic [7:0] RUN_BIAS    = 8'd127;

   localparam logic [2:0]  BPP_RGBA    = 3'd4;
   localparam logic [2:0]  BPP_RESET   = 3'd3;
   localparam logic [31:0] TOTAL_RESET = 32'd1;

   localparam logic [1:0] CSR_BPP   = 2'd0;
   localparam logic [1:0] CSR_TOTAL = 2'd1;

   // One decoded pixel, before the color bytes are put in output order.
   typedef struct packed {
      logic [7:0] blue;
      logic [7:0] green;
      logic [7:0] held_red;
      logic [7:0] last_byte;
      logic       rgba;
      logic [7:0] count;
      logic       done;
   } pix_type;

   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

endpackage

[src/trd_front.sv]
// Byte parser: packet headers, pixel assembly, run clipping and image completion.
module trd_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             accept,
   input  logic [7:0]       data_byte,
   input  logic [2:0]       bytes_per_pixel,
   input  logic [31:0]      total_pixels,
   output logic             emit,
   output trd_pkg::pix_type pix
);
   import trd_pkg::*;

   logic        expect_header_ff, expect_header_in;
   logic        run_packet_ff, run_packet_in;
   logic [7:0]  left_ff, left_in;
   logic [1:0]  byte_idx_ff, byte_idx_in;
   logic [23:0] held_ff, held_in;
   logic [31:0] emitted_ff, emitted_in;

   logic        rgba;
   logic [1:0]  last_idx;
   logic [7:0]  count_raw;
   logic [7:0]  left_dec;
   logic [31:0] remaining;

   always_comb begin
      rgba      = (bytes_per_pixel == BPP_RGBA);
      last_idx  = rgba ? 2'd3 : 2'd2;
      count_raw = run_packet_ff ? left_ff : 8'd1;
      if (count_raw == 8'd0) begin
         count_raw = 8'd1;
      end
      left_dec  = left_ff - 8'd1;
      remaining = total_pixels - emitted_ff;

      expect_header_in = expect_header_ff;
      run_packet_in    = run_packet_ff;
      left_in          = left_ff;
      byte_idx_in      = byte_idx_ff;
      held_in          = held_ff;
      emitted_in       = emitted_ff;

      emit          = 1'b0;
      pix.blue      = held_ff[7:0];
      pix.green     = held_ff[15:8];
      pix.held_red  = held_ff[23:16];
      pix.last_byte = data_byte;
      pix.rgba      = rgba;
      pix.count     = count_raw;
      pix.done      = 1'b0;

      // Clip the run to the pixels that remain; a total already reached
      // still finishes the image with a single pixel.
      if (emitted_ff >= total_pixels) begin
         pix.count = 8'd1;
         pix.done  = 1'b1;
      end else if ({24'd0, count_raw} >= remaining) begin
         pix.count = remaining[7:0];
         pix.done  = 1'b1;
      end

      if (accept) begin
         if (expect_header_ff) begin
            run_packet_in    = (data_byte >= HDR_RUN_MIN);
            left_in          = run_packet_in ? (data_byte - RUN_BIAS) : (data_byte + 8'd1);
            byte_idx_in      = 2'd0;
            expect_header_in = 1'b0;
         end else if (byte_idx_ff < last_idx) begin
            unique case (byte_idx_ff)
               2'd0: begin
                  held_in[7:0] = data_byte;
               end
               2'd1: begin
                  held_in[15:8] = data_byte;
               end
               default: begin
                  held_in[23:16] = data_byte;
               end
            endcase
            byte_idx_in = byte_idx_ff + 2'd1;
         end else begin
            emit        = 1'b1;
            byte_idx_in = 2'd0;
            if (!rgba) begin
               held_in[23:16] = data_byte;
            end
            if (pix.done) begin
               emitted_in       = 32'd0;
               expect_header_in = 1'b1;
               left_in          = 8'd0;
            end else begin
               emitted_in = emitted_ff + {24'd0, pix.count};
               if (run_packet_ff) begin
                  left_in          = 8'd0;
                  expect_header_in = 1'b1;
               end else begin
                  left_in = left_dec;
                  if (left_dec == 8'd0) begin
                     expect_header_in = 1'b1;
                  end
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         expect_header_ff <= 1'b1;
         run_packet_ff    <= 1'b0;
         left_ff          <= 8'd0;
         byte_idx_ff      <= 2'd0;
         held_ff          <= 24'd0;
         emitted_ff       <= 32'd0;
      end else begin
         expect_header_ff <= expect_header_in;
         run_packet_ff    <= run_packet_in;
         left_ff          <= left_in;
         byte_idx_ff      <= byte_idx_in;
         held_ff          <= held_in;
         emitted_ff       <= emitted_in;
      end
   end

endmodule

[src/trd_queue.sv]
// Short first-in first-out queue of decoded pixels between parser and output stage.
module trd_queue #(
   parameter int Depth = trd_pkg::QUEUE_DEPTH
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  trd_pkg::pix_type   push_data,
   input  logic               pop,
   output trd_pkg::pix_type   pop_data,
   output trd_pkg::qstat_type status
);
   import trd_pkg::*;

   localparam int AddrW  = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CountW = $clog2(Depth + 1);
   localparam logic [AddrW-1:0]  LastAddr  = AddrW'(Depth - 1);
   localparam logic [CountW-1:0] FullCount = CountW'(Depth);

   pix_type            slots_ff [Depth];
   logic [AddrW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [AddrW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CountW-1:0]  count_ff, count_in;
   logic               do_push, do_pop;

   always_comb begin
      status.full  = (count_ff == FullCount);
      status.empty = (count_ff == '0);
      do_push      = push && !status.full;
      do_pop       = pop && !status.empty;
      pop_data     = slots_ff[rd_ptr_ff];

      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LastAddr) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LastAddr) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

[src/trd_back.sv]
// Output stage: puts the color bytes in output order and holds the waiting result.
module trd_back (
   input  logic               clock,
   input  logic               reset,
   input  trd_pkg::qstat_type q_status,
   input  trd_pkg::pix_type   q_data,
   output logic               q_pop,
   input  logic               rsp_pop,
   output logic               rsp_empty,
   output logic [7:0]         rsp_red,
   output logic [7:0]         rsp_green,
   output logic [7:0]         rsp_blue,
   output logic [7:0]         rsp_alpha,
   output logic [7:0]         rsp_repeat_count,
   output logic               rsp_image_done
);
   import trd_pkg::*;

   logic       valid_ff, valid_in;
   logic [7:0] red_ff, green_ff, blue_ff, alpha_ff, count_ff;
   logic       done_ff;

   always_comb begin
      q_pop    = !q_status.empty && (!valid_ff || rsp_pop);
      valid_in = valid_ff;
      if (q_pop) begin
         valid_in = 1'b1;
      end else if (rsp_pop) begin
         valid_in = 1'b0;
      end
   end

   // In four-byte mode the last byte is alpha; otherwise it is red.
   always_ff @(posedge clock) begin
      if (q_pop) begin
         red_ff   <= q_data.rgba ? q_data.held_red : q_data.last_byte;
         green_ff <= q_data.green;
         blue_ff  <= q_data.blue;
         alpha_ff <= q_data.rgba ? q_data.last_byte : 8'd0;
         count_ff <= q_data.count;
         done_ff  <= q_data.done;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign rsp_empty        = !valid_ff;
   assign rsp_red          = red_ff;
   assign rsp_green        = green_ff;
   assign rsp_blue         = blue_ff;
   assign rsp_alpha        = alpha_ff;
   assign rsp_repeat_count = count_ff;
   assign rsp_image_done   = done_ff;

endmodule

[src/tga_rle_pixel_decoder_core.sv]
// TGA run-length pixel decoder. Takes one compressed byte per cycle whenever
// req_full is low; the parser updates its packet and pixel state in that same
// cycle, so the sustained rate is one byte per cycle while req_full stays low.
// The last color byte of a pixel writes one decoded pixel into a small queue,
// and the output register takes it from the queue once that register is empty
// or its result is being popped. req_full rises only when the result side has
// stalled long enough to fill the queue (QueueDepth entries plus the output
// register). A run packet gives a single result that carries its run length,
// clipped to the pixels left in the image; a raw packet gives one result per
// pixel. Configuration writes are always ready and should be made while idle.
`include "assert_macros.svh"

module tga_rle_pixel_decoder_core #(
   parameter int QueueDepth = trd_pkg::QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [7:0]  req_data_byte,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [7:0]  rsp_red,
   output logic [7:0]  rsp_green,
   output logic [7:0]  rsp_blue,
   output logic [7:0]  rsp_alpha,
   output logic [7:0]  rsp_repeat_count,
   output logic        rsp_image_done,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_data
);
   import trd_pkg::*;

   logic [2:0]  bpp_ff, bpp_in;
   logic [31:0] total_ff, total_in;

   logic      accept;
   logic      emit;
   pix_type   front_pix;
   pix_type   q_data;
   qstat_type q_status;
   logic      q_pop;

   assign csr_ready = 1'b1;
   assign req_full  = q_status.full;
   assign accept    = req_push && !q_status.full;

   always_comb begin
      bpp_in   = bpp_ff;
      total_in = total_ff;
      if (csr_valid && csr_ready) begin
         if (csr_index == CSR_BPP) begin
            bpp_in = csr_data[2:0];
         end else if (csr_index == CSR_TOTAL) begin
            total_in = csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bpp_ff   <= BPP_RESET;
         total_ff <= TOTAL_RESET;
      end else begin
         bpp_ff   <= bpp_in;
         total_ff <= total_in;
      end
   end

   trd_front u_front (
      .clock           (clock),
      .reset           (reset),
      .accept          (accept),
      .data_byte       (req_data_byte),
      .bytes_per_pixel (bpp_ff),
      .total_pixels    (total_ff),
      .emit            (emit),
      .pix             (front_pix)
   );

   trd_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (emit),
      .push_data (front_pix),
      .pop       (q_pop),
      .pop_data  (q_data),
      .status    (q_status)
   );

   trd_back u_back (
      .clock            (clock),
      .reset            (reset),
      .q_status         (q_status),
      .q_data           (q_data),
      .q_pop            (q_pop),
      .rsp_pop          (rsp_pop),
      .rsp_empty        (rsp_empty),
      .rsp_red          (rsp_red),
      .rsp_green        (rsp_green),
      .rsp_blue         (rsp_blue),
      .rsp_alpha        (rsp_alpha),
      .rsp_repeat_count (rsp_repeat_count),
      .rsp_image_done   (rsp_image_done)
   );

   `ASSERT_SYNC(a_count_range, !rsp_empty |-> (rsp_repeat_count != 8'd0 && rsp_repeat_count <= 8'd128), "repeat count out of range")
   `ASSERT_SYNC(a_rsp_holds, (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_red) && $stable(rsp_repeat_count)), "waiting result changed")
   `ASSERT_NEVER(a_queue_status, q_status.full && q_status.empty, "queue both full and empty")
   `ASSERT_SYNC(a_pop_fills, (q_pop && !rsp_pop) |=> !rsp_empty, "output stage not loaded after queue pop")

endmodule

[test/tb_tga_rle_pixel_decoder_core.sv]
// Self-checking testbench for the TGA run-length pixel decoder core.
`timescale 1ns / 1ps

module tb_tga_rle_pixel_decoder_core;
   import trd_pkg::*;

   localparam logic [1:0] CSR_SPARE  = 2'd3;  // not a register, writes must be ignored
   localparam int SETTLE_CYCLES      = 8;
   localparam int DRAIN_CYCLES       = 12;
   localparam int WATCHDOG_LIMIT     = 2000;
   localparam int PRESSURE_HOLD      = 80;
   localparam int NUM_PHASES         = 8;
   localparam int BYTES_PER_PHASE    = 125;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] alpha;
      logic [7:0] repeat_count;
      logic       image_done;
   } pixel_type;

   typedef enum logic [0:0] {ROW_BYTE, ROW_CSR} row_kind_type;

   typedef struct packed {
      row_kind_type kind;
      logic [1:0]   reg_idx;
      logic [31:0]  value;
      logic         typed;
      pixel_type    want;
   } dir_row_type;

   // Directed opening: clipping at a total of one, RGBA raw and full-length run,
   // a zero total, an ignored register index and a mode change in mid-pixel.
   localparam dir_row_type DIR_TABLE [31] = '{
      '{ROW_BYTE, '0, 32'hFF, 1'b0, '0},
      '{ROW_BYTE, '0, 32'h00, 1'b0, '0},
      '{ROW_BYTE, '0, 32'h00, 1'b0, '0},
      '{ROW_BYTE, '0, 32'hFF, 1'b1, '{8'hFF, 8'h00, 8'h00, 8'h00, 8'd1, 1'b1}},
      '{ROW_CSR, CSR_TOTAL, 32'd512, 1'b0, '0},
      '{ROW_CSR, CSR_BPP, 32'hFFFF_FFFC, 1'b0, '0},
      '{ROW_BYTE, '0, 32'h00, 1'b0, '0},
      '{ROW_BYTE, '0, 32'hFF, 1'b0, '0},
      '{ROW_BYTE, '0, 32'hFF, 1'b0, '0},
      '{ROW_BYTE, '0, 32'hFF, 1'b0, '0},
      '{ROW_BYTE, '0, 32'hFF, 1'b1, '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'd1, 1'b0}},
      '{ROW_BYTE, '0, 32'hFF, 1'b0, '0},
      '{ROW_BYTE, '0, 32'h10, 1'b0, '0},
      '{ROW_BYTE, '0, 32'h20, 1'b0, '0},
      '{ROW_BYTE, '0, 32'h30, 1'b0, '0},
      '{ROW_BYTE, '0, 32'h40, 1'b0, '0},
      '{ROW_CSR, CSR_TOTAL, 32'd0, 1'b0, '0},
      '{ROW_CSR, CSR_BPP, 32'd0, 1'b0, '0},
      '{ROW_BYTE, '0, 32'h7F, 1'b0, '0},
      '{ROW_BYTE, '0, 32'hAA, 1'b0, '0},
      '{ROW_BYTE, '0, 32'hBB, 1'b0, '0},
      '{ROW_BYTE, '0, 32'hCC, 1'b1, '{8'hCC, 8'hBB, 8'hAA, 8'h00, 8'd1, 1'b1}},
      '{ROW_CSR, CSR_SPARE, 32'hFFFF_FFFF, 1'b0, '0},
      '{ROW_CSR, CSR_TOTAL, 32'hFFFF_FFFF, 1'b0, '0},
      '{ROW_CSR, CSR_BPP, 32'd4, 1'b0, '0},
      '{ROW_BYTE, '0, 32'h80, 1'b0, '0},
      '{ROW_BYTE, '0, 32'h01, 1'b0, '0},
      '{ROW_BYTE, '0, 32'h02, 1'b0, '0},
      '{ROW_BYTE, '0, 32'h03, 1'b0, '0},
      '{ROW_CSR, CSR_BPP, 32'd3, 1'b0, '0},
      '{ROW_BYTE, '0, 32'h04, 1'b0, '0}
   };

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_push = 1'b0;
   logic        req_full;
   logic [7:0]  req_data_byte = 8'd0;
   logic        rsp_empty;
   logic        rsp_pop = 1'b0;
   logic [7:0]  rsp_red;
   logic [7:0]  rsp_green;
   logic [7:0]  rsp_blue;
   logic [7:0]  rsp_alpha;
   logic [7:0]  rsp_repeat_count;
   logic        rsp_image_done;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = 2'd0;
   logic [31:0] csr_data = 32'd0;

   // Decoder state as the predictor sees it.
   logic [2:0]  cfg_bpp;
   logic [31:0] cfg_total;
   logic        want_header;
   logic        run_mode;
   logic [7:0]  packet_left;
   logic [1:0]  pix_byte;
   logic [23:0] color_hold;
   logic [31:0] pixels_out;

   pixel_type pending_pixels[$];
   int     mismatch_count = 0;
   int     idle_cycles = 0;
   int     rsp_hold_cycles = 0;
   bit     req_idle_on = 1'b1;
   bit     rsp_idle_on = 1'b1;

   tga_rle_pixel_decoder_core dut (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_data_byte    (req_data_byte),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_red          (rsp_red),
      .rsp_green        (rsp_green),
      .rsp_blue         (rsp_blue),
      .rsp_alpha        (rsp_alpha),
      .rsp_repeat_count (rsp_repeat_count),
      .rsp_image_done   (rsp_image_done),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic void reset_decoder_state();
      cfg_bpp     = BPP_RESET;
      cfg_total   = TOTAL_RESET;
      want_header = 1'b1;
      run_mode    = 1'b0;
      packet_left = 8'd0;
      pix_byte    = 2'd0;
      color_hold  = 24'd0;
      pixels_out  = 32'd0;
   endfunction

   // Advances the decoder state by one byte; returns 1 when the byte completes a pixel.
   function automatic bit decode_byte(input logic [7:0] b, output pixel_type px);
      logic        rgba;
      logic [1:0]  last_idx;
      logic [31:0] count;
      logic [31:0] remaining;
      logic        done;
      rgba     = (cfg_bpp == BPP_RGBA);
      last_idx = rgba ? 2'd3 : 2'd2;
      px       = '0;
      if (want_header) begin
         run_mode    = (b >= HDR_RUN_MIN);
         packet_left = run_mode ? b - RUN_BIAS : b + 8'd1;
         pix_byte    = 2'd0;
         want_header = 1'b0;
         return 1'b0;
      end
      if (pix_byte < last_idx) begin
         unique case (pix_byte)
            2'd0: color_hold[7:0] = b;
            2'd1: color_hold[15:8] = b;
            default: color_hold[23:16] = b;
         endcase
         pix_byte = pix_byte + 2'd1;
         return 1'b0;
      end
      px.blue  = color_hold[7:0];
      px.green = color_hold[15:8];
      if (rgba) begin
         px.red   = color_hold[23:16];
         px.alpha = b;
      end else begin
         px.red   = b;
         px.alpha = 8'd0;
         color_hold[23:16] = b;
      end
      pix_byte = 2'd0;
      count = run_mode ? 32'(packet_left) : 32'd1;
      if (count == 32'd0) count = 32'd1;
      // A total already reached (zero, or lowered mid-image) ends the image at once.
      if (pixels_out >= cfg_total) begin
         count = 32'd1;
         done  = 1'b1;
      end else begin
         remaining = cfg_total - pixels_out;
         done = (count >= remaining);
         if (done) count = remaining;
      end
      if (done) begin
         pixels_out  = 32'd0;
         want_header = 1'b1;
         packet_left = 8'd0;
      end else begin
         pixels_out = pixels_out + count;
         if (run_mode) begin
            packet_left = 8'd0;
            want_header = 1'b1;
         end else begin
            packet_left = packet_left - 8'd1;
            if (packet_left == 8'd0) want_header = 1'b1;
         end
      end
      px.repeat_count = count[7:0];
      px.image_done   = done;
      return 1'b1;
   endfunction

   task automatic report_mismatch(input string what, input logic [7:0] got,
                                  input logic [7:0] want);
      mismatch_count++;
      $display("MISMATCH at %0t ns: %s got 0x%0h expected 0x%0h", $time, what, got, want);
   endtask

   task automatic check_pixel(input pixel_type got);
      pixel_type want;
      if (pending_pixels.size() == 0) begin
         report_mismatch("result with nothing expected", got.repeat_count, 8'd0);
         return;
      end
      want = pending_pixels.pop_front();
      if (got.red !== want.red) report_mismatch("red", got.red, want.red);
      if (got.green !== want.green) report_mismatch("green", got.green, want.green);
      if (got.blue !== want.blue) report_mismatch("blue", got.blue, want.blue);
      if (got.alpha !== want.alpha) report_mismatch("alpha", got.alpha, want.alpha);
      if (got.repeat_count !== want.repeat_count)
         report_mismatch("repeat_count", got.repeat_count, want.repeat_count);
      if (got.image_done !== want.image_done)
         report_mismatch("image_done", {7'd0, got.image_done}, {7'd0, want.image_done});
   endtask

   task automatic send_byte(input logic [7:0] b, input logic use_typed,
                            input pixel_type typed_px);
      int        gap;
      pixel_type px;
      gap = req_idle_on ? $urandom_range(0, 3) : 0;
      if (gap != 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_push      <= 1'b1;
      req_data_byte <= b;
      do @(posedge clock); while (req_full !== 1'b0);
      if (decode_byte(b, px)) pending_pixels.push_back(use_typed ? typed_px : px);
   endtask

   // Register writes only happen with no pixel in flight inside the block.
   task automatic settle();
      req_push <= 1'b0;
      while (pending_pixels.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (csr_ready !== 1'b1);
      csr_valid <= 1'b0;
      unique case (idx)
         CSR_BPP:   cfg_bpp = value[2:0];
         CSR_TOTAL: cfg_total = value;
         default: ;
      endcase
      @(posedge clock);
   endtask

   // Follows the packet structure: a header whenever one is due, color bytes otherwise.
   function automatic logic [7:0] next_stream_byte();
      if (want_header) begin
         unique case ($urandom_range(0, 9))
            0, 1, 2, 3: return 8'($urandom_range(128, 255));
            4, 5, 6, 7, 8: return 8'($urandom_range(0, 7));
            default: return 8'($urandom_range(0, 127));
         endcase
      end
      unique case ($urandom_range(0, 7))
         0: return 8'h00;
         1: return 8'hFF;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic logic [31:0] pick_bpp_word();
      unique case ($urandom_range(0, 3))
         0: return 32'd3;
         1: return 32'd4;
         2: return 32'($urandom_range(0, 7));
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [31:0] pick_total();
      unique case ($urandom_range(0, 5))
         0: return 32'($urandom_range(1, 4));
         1: return 32'($urandom_range(5, 300));
         2: return 32'hFFFF_FFFF;
         3: return $urandom;
         4: return 32'd0;
         default: return 32'($urandom_range(1, 40));
      endcase
   endfunction

   // Result side: random stalls per beat, plus a long hold-off on request.
   initial begin
      pixel_type got;
      int        gap;
      wait (reset === 1'b0);
      forever begin
         if (rsp_hold_cycles != 0) begin
            rsp_pop <= 1'b0;
            repeat (rsp_hold_cycles) @(posedge clock);
            rsp_hold_cycles = 0;
         end
         gap = rsp_idle_on ? $urandom_range(0, 3) : 0;
         if (gap != 0) begin
            rsp_pop <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_pop <= 1'b1;
         do @(posedge clock); while (rsp_empty !== 1'b0);
         got = '{rsp_red, rsp_green, rsp_blue, rsp_alpha, rsp_repeat_count, rsp_image_done};
         check_pixel(got);
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         idle_cycles <= 0;
      end else if ((req_push && !req_full) || (rsp_pop && !rsp_empty) ||
                   (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      dir_row_type row;
      int          phase;
      reset_decoder_state();
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < $size(DIR_TABLE); i++) begin
         row = DIR_TABLE[i];
         if (row.kind == ROW_CSR) begin
            settle();
            write_reg(row.reg_idx, row.value);
         end else begin
            send_byte(row.value[7:0], row.typed, row.want);
         end
      end

      for (phase = 0; phase < NUM_PHASES; phase++) begin
         settle();
         req_idle_on = (phase % 3) != 0;
         rsp_idle_on = (phase % 4) != 1;
         write_reg(CSR_BPP, pick_bpp_word());
         write_reg(CSR_TOTAL, pick_total());
         if ($urandom_range(0, 3) == 0) write_reg(CSR_SPARE, $urandom);
         // Stall the result side while bytes keep coming, so the block backs up.
         if (phase == 2 || phase == 5) begin
            req_idle_on = 1'b0;
            rsp_hold_cycles = PRESSURE_HOLD;
         end
         repeat (BYTES_PER_PHASE) send_byte(next_stream_byte(), 1'b0, '0);
      end

      req_push <= 1'b0;
      while (pending_pixels.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

[tga_rle_pixel_decoder_core.f]
+incdir+src
src/trd_pkg.sv
src/trd_front.sv
src/trd_queue.sv
src/trd_back.sv
src/tga_rle_pixel_decoder_core.sv
test/tb_tga_rle_pixel_decoder_core.sv
